// ===== design/gbsg_pkg.sv =====
// Package for the Gaussian blur + Sobel gradient core.
// Holds field widths, fixed window constants and the stage-to-stage structs.
// No dependencies.
package gbsg_pkg;

   // payload and register widths
   localparam int PIX_W   = 8;
   localparam int BLUR_W  = 12;
   localparam int GRAD_W  = 15;
   localparam int CSR_W   = 11;
   localparam int ROW_W   = 16;

   // line width limits and reset value
   localparam int MIN_WIDTH   = 5;
   localparam int RESET_WIDTH = 640;

   // first column that has a full raw window, first column and row with a full
   // blur window
   localparam int BLUR_COL = 2;
   localparam int EMIT_COL = 4;
   localparam int EMIT_ROW = 4;

   // per-beat flags that travel with a pixel down the pipe
   typedef struct packed {
      logic valid;
      logic last;
      logic row_ok;
   } beat_tag_type;

   // pipeline control shared by both stages
   typedef struct packed {
      logic advance;
      logic clear;
   } pipe_ctrl_type;

endpackage

// ===== design/gbsg_req_if.sv =====
// Pixel request channel: valid/ready handshake with pixel and frame_start.
// Depends on gbsg_pkg for the pixel width.
interface gbsg_req_if;
   logic                        valid;
   logic                        ready;
   logic [gbsg_pkg::PIX_W-1:0]  pixel;
   logic                        frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== design/gbsg_rsp_if.sv =====
// Gradient response channel: valid/ready handshake with grad_x, grad_y, row_end.
// Depends on gbsg_pkg for the gradient width.
interface gbsg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gbsg_pkg::GRAD_W-1:0] grad_x;
   logic signed [gbsg_pkg::GRAD_W-1:0] grad_y;
   logic                               row_end;

   modport source (output valid, output grad_x, output grad_y, output row_end, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input row_end, output ready);
endinterface

// ===== design/gbsg_raw_stage.sv =====
// Raw side: row/column counters, two-row raw line store, 3x3 raw window and
// the Gaussian sum. Depends on gbsg_pkg.
module gbsg_raw_stage #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gbsg_pkg::pipe_ctrl_type      ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0] clr_addr,
   input  logic                         in_valid,
   input  logic [gbsg_pkg::PIX_W-1:0]   pixel,
   input  logic                         frame_start,
   input  logic [$clog2(MAX_WIDTH)-1:0] wm1,
   output gbsg_pkg::beat_tag_type       a_tag,
   output logic [$clog2(MAX_WIDTH)-1:0] a_col,
   output gbsg_pkg::beat_tag_type       b_tag,
   output logic [$clog2(MAX_WIDTH)-1:0] b_col,
   output logic [gbsg_pkg::BLUR_W-1:0]  b_sum
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PW = gbsg_pkg::PIX_W;
   localparam int BW = gbsg_pkg::BLUR_W;
   localparam int RW = gbsg_pkg::ROW_W;

   // position counters
   logic [CW-1:0] col_ff, col_in, c0;
   logic [RW-1:0] row_ff, row_in, r0;
   logic          last0;

   // stage A
   gbsg_pkg::beat_tag_type a_tag_ff, b_tag_ff;
   logic [CW-1:0]          a_col_ff, b_col_ff;
   logic [PW-1:0]          a_pix_ff;

   // line store: {top, mid} per column
   logic [2*PW-1:0] raw_mem [MAX_WIDTH];
   logic [2*PW-1:0] raw_rd_ff;
   logic [2*PW-1:0] fwd_data_ff;
   logic            fwd_ff;
   logic [PW-1:0]   a_top, a_mid;

   // window, index row*3 + column, column 0 oldest
   logic [PW-1:0] win_ff [9];

   // position of the incoming pixel
   always_comb begin
      c0     = frame_start ? '0 : col_ff;
      r0     = frame_start ? '0 : row_ff;
      last0  = (c0 >= wm1);
      col_in = last0 ? '0 : c0 + CW'(1);
      if (last0 && (r0 != '1)) begin
         row_in = r0 + RW'(1);
      end else begin
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_valid) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage A registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
      end else if (ctrl.advance) begin
         a_tag_ff.valid  <= in_valid;
         a_tag_ff.last   <= last0;
         a_tag_ff.row_ok <= (r0 >= RW'(gbsg_pkg::EMIT_ROW));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         a_col_ff <= c0;
         a_pix_ff <= pixel;
      end
   end

   // pick up the write of the beat just ahead when it hits the same column
   assign a_top = fwd_ff ? fwd_data_ff[2*PW-1:PW] : raw_rd_ff[2*PW-1:PW];
   assign a_mid = fwd_ff ? fwd_data_ff[PW-1:0]    : raw_rd_ff[PW-1:0];

   // line store: clear sweep, else rotate rows at the stage A column
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         raw_mem[clr_addr] <= '0;
      end else if (ctrl.advance && a_tag_ff.valid) begin
         raw_mem[a_col_ff] <= {a_mid, a_pix_ff};
      end
      if (ctrl.advance) begin
         raw_rd_ff   <= raw_mem[c0];
         fwd_data_ff <= {a_mid, a_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (ctrl.advance) begin
         fwd_ff <= a_tag_ff.valid && (a_col_ff == c0);
      end
   end

   // shift the window by one column
   always_ff @(posedge clock) begin
      if (ctrl.advance && a_tag_ff.valid) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= a_top;
         win_ff[5] <= a_mid;
         win_ff[8] <= a_pix_ff;
      end
   end

   // stage B registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_tag_ff <= '0;
      end else if (ctrl.advance) begin
         b_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         b_col_ff <= a_col_ff;
      end
   end

   // Gaussian 1 2 1 / 2 4 2 / 1 2 1, kept at 16 times the blur
   always_comb begin
      b_sum = BW'(win_ff[0]) + (BW'(win_ff[1]) << 1) + BW'(win_ff[2])
            + (BW'(win_ff[3]) << 1) + (BW'(win_ff[4]) << 2) + (BW'(win_ff[5]) << 1)
            + BW'(win_ff[6]) + (BW'(win_ff[7]) << 1) + BW'(win_ff[8]);
   end

   assign a_tag = a_tag_ff;
   assign a_col = a_col_ff;
   assign b_tag = b_tag_ff;
   assign b_col = b_col_ff;

`ifndef SYNTHESIS
   // row never steps back without a frame start
   a_row_mono: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !frame_start) |=> (row_ff >= $past(row_ff)))
      else $error("row counter went back without frame start");
   // forwarding only follows a live beat in stage A
   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && !a_tag_ff.valid) |=> !fwd_ff)
      else $error("raw forward without a writer");
   // a wrapped beat restarts the column
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      (in_valid && last0) |=> (col_ff == '0))
      else $error("column did not wrap");
`endif

endmodule

// ===== design/gbsg_blur_stage.sv =====
// Blur side: two-row blur line store, 3x3 blur window and the Sobel X/Y sums.
// Depends on gbsg_pkg.
module gbsg_blur_stage #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gbsg_pkg::pipe_ctrl_type             ctrl,
   input  logic [$clog2(MAX_WIDTH)-1:0]        clr_addr,
   input  gbsg_pkg::beat_tag_type              a_tag,
   input  logic [$clog2(MAX_WIDTH)-1:0]        a_col,
   input  gbsg_pkg::beat_tag_type              b_tag,
   input  logic [$clog2(MAX_WIDTH)-1:0]        b_col,
   input  logic [gbsg_pkg::BLUR_W-1:0]         b_sum,
   output logic                                c_valid,
   output logic                                c_last,
   output logic signed [gbsg_pkg::GRAD_W-1:0]  grad_x,
   output logic signed [gbsg_pkg::GRAD_W-1:0]  grad_y
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int BW = gbsg_pkg::BLUR_W;
   localparam int SW = BW + 4;

   logic [2*BW-1:0] blur_mem [MAX_WIDTH];
   logic [2*BW-1:0] blur_rd_ff;
   logic [2*BW-1:0] fwd_data_ff;
   logic            fwd_ff;
   logic [BW-1:0]   b_top, b_mid;
   logic            b_wr;
   logic [CW-1:0]   rd_addr, wr_addr;

   logic [BW-1:0]   bwin_ff [9];
   logic            c_valid_ff, c_last_ff;

   logic signed [SW-1:0] s [9];
   logic signed [SW-1:0] gx_full, gy_full;

   // blur column trails the raw column by two
   assign rd_addr = a_col - CW'(gbsg_pkg::BLUR_COL);
   assign wr_addr = b_col - CW'(gbsg_pkg::BLUR_COL);
   assign b_wr    = b_tag.valid && (b_col >= CW'(gbsg_pkg::BLUR_COL));

   assign b_top = fwd_ff ? fwd_data_ff[2*BW-1:BW] : blur_rd_ff[2*BW-1:BW];
   assign b_mid = fwd_ff ? fwd_data_ff[BW-1:0]    : blur_rd_ff[BW-1:0];

   // line store: clear sweep, else rotate rows at the stage B column
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         blur_mem[clr_addr] <= '0;
      end else if (ctrl.advance && b_wr) begin
         blur_mem[wr_addr] <= {b_mid, b_sum};
      end
      if (ctrl.advance) begin
         blur_rd_ff  <= blur_mem[rd_addr];
         fwd_data_ff <= {b_mid, b_sum};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (ctrl.advance) begin
         fwd_ff <= b_wr && a_tag.valid && (a_col == b_col);
      end
   end

   // shift the blur window by one column
   always_ff @(posedge clock) begin
      if (ctrl.advance && b_wr) begin
         for (int k = 0; k < 3; k++) begin
            bwin_ff[k*3]   <= bwin_ff[k*3+1];
            bwin_ff[k*3+1] <= bwin_ff[k*3+2];
         end
         bwin_ff[2] <= b_top;
         bwin_ff[5] <= b_mid;
         bwin_ff[8] <= b_sum;
      end
   end

   // stage C: emit only where both windows are inside the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         c_valid_ff <= b_tag.valid && b_tag.row_ok && (b_col >= CW'(gbsg_pkg::EMIT_COL));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         c_last_ff <= b_tag.last;
      end
   end

   // Sobel X and Y over the blur window
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         s[k] = signed'(SW'(bwin_ff[k]));
      end
      gx_full = (s[2] - s[0]) + ((s[5] - s[3]) <<< 1) + (s[8] - s[6]);
      gy_full = (s[6] - s[0]) + ((s[7] - s[1]) <<< 1) + (s[8] - s[2]);
   end

   assign grad_x  = gx_full[gbsg_pkg::GRAD_W-1:0];
   assign grad_y  = gy_full[gbsg_pkg::GRAD_W-1:0];
   assign c_valid = c_valid_ff;
   assign c_last  = c_last_ff;

`ifndef SYNTHESIS
   // a column below four never makes a result
   c_col_gate: assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && (b_col < CW'(gbsg_pkg::EMIT_COL))) |=> !c_valid_ff)
      else $error("result from a partial blur window");
   // blur forwarding only follows a blur write
   c_fwd_src: assert property (@(posedge clock) disable iff (reset)
      (ctrl.advance && !b_wr) |=> !fwd_ff)
      else $error("blur forward without a writer");
`endif

endmodule

// ===== design/gaussian_blur_sobel_gradient_core.sv =====
// Top level of the Gaussian blur + Sobel gradient core: width register,
// line store clear sweep, pipeline control and result register.
// Depends on gbsg_pkg, gbsg_req_if, gbsg_rsp_if, gbsg_raw_stage, gbsg_blur_stage.
//
//   channel  dir  payload                          beat when
//   req_bus  in   pixel[7:0], frame_start           valid && ready
//   rsp_bus  out  grad_x[14:0], grad_y[14:0], row_end  valid && ready
//   csr      in   csr_wr_data[10:0] (line_width)    csr_wr_en
//
// One pixel per clock while req_bus.ready is high; a result reaches the result
// register through stage A, stage B and stage C.
// The whole pipe advances together; it holds only while the result register
// is full and rsp_bus.ready is low.
// After reset a clear sweep zeroes both line stores, one column per cycle, so
// req_bus.ready stays low until the sweep ends.
// Reset is synchronous; line_width returns to 640 (clamped to MAX_WIDTH).
module gaussian_blur_sobel_gradient_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   gbsg_req_if.sink                       req_bus,
   gbsg_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [gbsg_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > gbsg_pkg::CSR_W) ? CW + 1 : gbsg_pkg::CSR_W;
   localparam int RST_W = (gbsg_pkg::RESET_WIDTH < MAX_WIDTH) ?
                          gbsg_pkg::RESET_WIDTH : MAX_WIDTH;

   // effective width minus one
   logic [CW-1:0] wm1_ff, wm1_in;
   logic [LW-1:0] lw_ext;

   // clear sweep
   logic          clr_busy_ff;
   logic [CW-1:0] clr_addr_ff;

   gbsg_pkg::pipe_ctrl_type ctrl;
   logic                    accept;

   gbsg_pkg::beat_tag_type  a_tag, b_tag;
   logic [CW-1:0]           a_col, b_col;
   logic [gbsg_pkg::BLUR_W-1:0] b_sum;
   logic                    c_valid, c_last;
   logic signed [gbsg_pkg::GRAD_W-1:0] gx, gy;

   // result register
   logic                               rsp_valid_ff;
   logic signed [gbsg_pkg::GRAD_W-1:0] rsp_gx_ff, rsp_gy_ff;
   logic                               rsp_last_ff;

   // clamp the written width into range
   always_comb begin
      lw_ext = LW'(csr_wr_data);
      if (lw_ext < LW'(gbsg_pkg::MIN_WIDTH)) begin
         wm1_in = CW'(gbsg_pkg::MIN_WIDTH - 1);
      end else if (lw_ext > LW'(MAX_WIDTH)) begin
         wm1_in = CW'(MAX_WIDTH - 1);
      end else begin
         wm1_in = CW'(lw_ext - LW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff <= CW'(RST_W - 1);
      end else if (csr_wr_en) begin
         wm1_ff <= wm1_in;
      end
   end

   // sweep the line stores once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + CW'(1);
         if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // advance the pipe unless a result is stuck
   assign ctrl.advance  = !rsp_valid_ff || rsp_bus.ready;
   assign ctrl.clear    = clr_busy_ff;
   assign req_bus.ready = ctrl.advance && !clr_busy_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   gbsg_raw_stage #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raw (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .clr_addr    (clr_addr_ff),
      .in_valid    (accept),
      .pixel       (req_bus.pixel),
      .frame_start (req_bus.frame_start),
      .wm1         (wm1_ff),
      .a_tag       (a_tag),
      .a_col       (a_col),
      .b_tag       (b_tag),
      .b_col       (b_col),
      .b_sum       (b_sum)
   );

   gbsg_blur_stage #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_blur (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .clr_addr (clr_addr_ff),
      .a_tag    (a_tag),
      .a_col    (a_col),
      .b_tag    (b_tag),
      .b_col    (b_col),
      .b_sum    (b_sum),
      .c_valid  (c_valid),
      .c_last   (c_last),
      .grad_x   (gx),
      .grad_y   (gy)
   );

   // load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         rsp_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance && c_valid) begin
         rsp_gx_ff   <= gx;
         rsp_gy_ff   <= gy;
         rsp_last_ff <= c_last;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.grad_x  = rsp_gx_ff;
   assign rsp_bus.grad_y  = rsp_gy_ff;
   assign rsp_bus.row_end = rsp_last_ff;

`ifndef SYNTHESIS
   // no pixel taken during the clear sweep
   t_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_bus.ready)
      else $error("pixel taken during clear sweep");
   // no result can exist during the clear sweep
   t_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !rsp_valid_ff)
      else $error("result during clear sweep");
   // sweep ends only after the last column
   t_clr_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> ($past(clr_addr_ff) == CW'(MAX_WIDTH - 1)))
      else $error("clear sweep ended early");
`endif

endmodule

// ===== dv/gaussian_blur_sobel_gradient_checker.sv =====
// Scoreboard for the Gaussian blur + Sobel gradient core: watches the pixel, gradient
// and width-register ports, predicts each gradient beat and compares it field by field.
// Depends on gbsg_pkg, gbsg_req_if and gbsg_rsp_if.
module gaussian_blur_sobel_gradient_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   gbsg_req_if                        req_bus,
   gbsg_rsp_if                        rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [gbsg_pkg::CSR_W-1:0] csr_wr_data,
   output int unsigned                mismatch_count,
   output int unsigned                gradients_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_MAX = (1 << gbsg_pkg::ROW_W) - 1;

   typedef struct packed {
      logic signed [gbsg_pkg::GRAD_W-1:0] grad_x;
      logic signed [gbsg_pkg::GRAD_W-1:0] grad_y;
      logic                               row_end;
   } gradient_type;

   // gradients predicted but not yet seen on the result channel, oldest first
   gradient_type expected_gradients[$];

   // shadow of the block: width register, two raw rows, two blur rows, both windows
   logic [gbsg_pkg::CSR_W-1:0]  line_width;
   logic [gbsg_pkg::PIX_W-1:0]  raw_rows  [2*MAX_WIDTH];
   logic [gbsg_pkg::BLUR_W-1:0] blur_rows [2*MAX_WIDTH];
   logic [gbsg_pkg::PIX_W-1:0]  raw_win   [9];
   logic [gbsg_pkg::BLUR_W-1:0] blur_win  [9];
   int unsigned                 col_pos;
   int unsigned                 row_pos;

   // width in use: clamp the register into [MIN_WIDTH, MAX_WIDTH]
   function automatic int unsigned active_width();
      int unsigned w;
      w = line_width;
      if (w < gbsg_pkg::MIN_WIDTH) w = gbsg_pkg::MIN_WIDTH;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   // advance the shadow by one pixel and queue the gradient it yields, if any
   function automatic void predict_gradient(input logic [gbsg_pkg::PIX_W-1:0] pix,
                                            input logic frame_start);
      int unsigned                 w;
      int unsigned                 c;
      int unsigned                 bc;
      logic [gbsg_pkg::PIX_W-1:0]  raw_top;
      logic [gbsg_pkg::PIX_W-1:0]  raw_mid;
      logic [gbsg_pkg::BLUR_W-1:0] blur_top;
      logic [gbsg_pkg::BLUR_W-1:0] blur_mid;
      logic [gbsg_pkg::BLUR_W-1:0] blur_new;
      int                          s [9];
      int                          gx;
      int                          gy;
      gradient_type                g;

      w = active_width();
      if (frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= MAX_WIDTH) col_pos = 0;
      c = col_pos;

      // raw column: rotate the two stored rows, shift the window left
      raw_top = raw_rows[c];
      raw_mid = raw_rows[MAX_WIDTH + c];
      raw_rows[c] = raw_mid;
      raw_rows[MAX_WIDTH + c] = pix;
      for (int k = 0; k < 3; k++) begin
         raw_win[k*3]     = raw_win[k*3 + 1];
         raw_win[k*3 + 1] = raw_win[k*3 + 2];
      end
      raw_win[2] = raw_top;
      raw_win[5] = raw_mid;
      raw_win[8] = pix;

      if (c >= gbsg_pkg::BLUR_COL) begin
         // blur kept at 16x scale, so it is exact in BLUR_W bits
         bc = c - gbsg_pkg::BLUR_COL;
         blur_new = raw_win[0] + 2*raw_win[1] + raw_win[2]
                  + 2*raw_win[3] + 4*raw_win[4] + 2*raw_win[5]
                  + raw_win[6] + 2*raw_win[7] + raw_win[8];
         blur_top = blur_rows[bc];
         blur_mid = blur_rows[MAX_WIDTH + bc];
         blur_rows[bc] = blur_mid;
         blur_rows[MAX_WIDTH + bc] = blur_new;
         for (int k = 0; k < 3; k++) begin
            blur_win[k*3]     = blur_win[k*3 + 1];
            blur_win[k*3 + 1] = blur_win[k*3 + 2];
         end
         blur_win[2] = blur_top;
         blur_win[5] = blur_mid;
         blur_win[8] = blur_new;

         if (c >= gbsg_pkg::EMIT_COL && row_pos >= gbsg_pkg::EMIT_ROW) begin
            for (int k = 0; k < 9; k++) s[k] = blur_win[k];
            gx = (s[2] - s[0]) + 2*(s[5] - s[3]) + (s[8] - s[6]);
            gy = (s[6] + 2*s[7] + s[8]) - (s[0] + 2*s[1] + s[2]);
            g.grad_x  = gx[gbsg_pkg::GRAD_W-1:0];
            g.grad_y  = gy[gbsg_pkg::GRAD_W-1:0];
            g.row_end = (c >= w - 1);
            expected_gradients.push_back(g);
         end
      end

      // wrap the column at the row end; the row counter saturates
      if (c >= w - 1) begin
         col_pos = 0;
         if (row_pos < ROW_MAX) row_pos++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   always @(posedge clock) begin
      gradient_type want;
      logic         bad;

      if (reset) begin
         line_width = gbsg_pkg::RESET_WIDTH;
         for (int k = 0; k < 2*MAX_WIDTH; k++) begin
            raw_rows[k]  = '0;
            blur_rows[k] = '0;
         end
         for (int k = 0; k < 9; k++) begin
            raw_win[k]  = '0;
            blur_win[k] = '0;
         end
         col_pos = 0;
         row_pos = 0;
         mismatch_count = 0;
         expected_gradients.delete();
      end else begin
         if (csr_wr_en) line_width = csr_wr_data;

         // check a gradient beat against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_gradients.size() == 0) begin
               $display("%0t: unexpected gradient, expected none, actual gx %0d gy %0d end %0b",
                        $time, rsp_bus.grad_x, rsp_bus.grad_y, rsp_bus.row_end);
               mismatch_count++;
            end else begin
               want = expected_gradients.pop_front();
               bad  = 1'b0;
               if (rsp_bus.grad_x !== want.grad_x) begin
                  bad = 1'b1;
                  $display("%0t: grad_x mismatch, expected %0d, actual %0d",
                           $time, want.grad_x, rsp_bus.grad_x);
               end
               if (rsp_bus.grad_y !== want.grad_y) begin
                  bad = 1'b1;
                  $display("%0t: grad_y mismatch, expected %0d, actual %0d",
                           $time, want.grad_y, rsp_bus.grad_y);
               end
               if (rsp_bus.row_end !== want.row_end) begin
                  bad = 1'b1;
                  $display("%0t: row_end mismatch, expected %0b, actual %0b",
                           $time, want.row_end, rsp_bus.row_end);
               end
               if (bad) mismatch_count++;
            end
         end

         // predict from an accepted pixel beat
         if (req_bus.valid && req_bus.ready)
            predict_gradient(req_bus.pixel, req_bus.frame_start);
      end
      gradients_outstanding = expected_gradients.size();
   end

endmodule

// ===== dv/gaussian_blur_sobel_gradient_core_tb.sv =====
// Testbench top for the Gaussian blur + Sobel gradient core: clock, reset, pixel
// stimulus, result back-pressure and the verdict.
// Depends on gbsg_pkg, both channel interfaces, the core and the gradient checker.
module gaussian_blur_sobel_gradient_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH    = 1024;
   localparam int RANDOM_ITEMS = 560;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int CSR_MAX      = (1 << gbsg_pkg::CSR_W) - 1;

   localparam logic [gbsg_pkg::PIX_W-1:0] PIX_HI = '1;
   localparam logic [gbsg_pkg::PIX_W-1:0] PIX_LO = '0;

   typedef enum {
      PAT_RANDOM,
      PAT_WHITE,
      PAT_BLACK,
      PAT_CHECKER,
      PAT_VEDGE,
      PAT_HEDGE,
      PAT_SPECKLE
   } pattern_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [gbsg_pkg::CSR_W-1:0] csr_wr_data;
   int unsigned                mismatch_count;
   int unsigned                gradients_outstanding;
   int unsigned                cycle_count = 0;
   int unsigned                items_sent = 0;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;
   bit                         rsp_hold_request = 1'b0;

   gbsg_req_if req_bus ();
   gbsg_rsp_if rsp_bus ();

   gaussian_blur_sobel_gradient_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gaussian_blur_sobel_gradient_checker #(.MAX_WIDTH(MAX_WIDTH)) gradient_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_bus               (req_bus),
      .rsp_bus               (rsp_bus),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .mismatch_count        (mismatch_count),
      .gradients_outstanding (gradients_outstanding)
   );

   always #5 clock = ~clock;

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 50;
      endcase
   endfunction

   function automatic logic [gbsg_pkg::PIX_W-1:0] pixel_for(input pattern_type pat,
                                                            input int r, input int c,
                                                            input int width);
      case (pat)
         PAT_WHITE:   return PIX_HI;
         PAT_BLACK:   return PIX_LO;
         PAT_CHECKER: return ((r + c) % 2 != 0) ? PIX_HI : PIX_LO;
         PAT_VEDGE:   return (c >= width / 2) ? PIX_HI : PIX_LO;
         PAT_HEDGE:   return (r >= 2) ? PIX_HI : PIX_LO;
         PAT_SPECKLE: return ($urandom_range(0, 7) == 0) ? PIX_HI
                                                         : gbsg_pkg::PIX_W'($urandom_range(0, 3));
         default:     return gbsg_pkg::PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // offer one pixel beat after a random gap, hold until it is taken
   task automatic send_pixel(input logic [gbsg_pkg::PIX_W-1:0] pix, input logic fs);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= pix;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      items_sent++;
   endtask

   // send rows x width pixels; noise_pm is the per-mille rate of stray frame starts
   task automatic send_block(input int rows, input int width, input pattern_type pat,
                             input bit new_frame, input int noise_pm);
      logic fs;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < width; c++) begin
            fs = (new_frame && r == 0 && c == 0) || ($urandom_range(0, 999) < noise_pm);
            send_pixel(pixel_for(pat, r, c, width), fs);
         end
      end
   endtask

   // drop valid, wait for every predicted gradient, then let the pipe empty
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (gradients_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[gbsg_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // result side: random stalls per beat, plus one long hold on request
   initial begin : result_sink
      int idle;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_request) begin
            idle = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            idle = $urandom_range(1, 19);
         end else begin
            idle = 0;
         end
         if (idle > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   initial begin : pixel_source
      int          value;
      int          ew;
      int          rows;
      bit          new_frame;
      pattern_type pat;
      int unsigned random_target;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.pixel       <= '0;
      req_bus.frame_start <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset width, no frame start: the first pixel opens the frame
      send_block(1, 6, PAT_RANDOM, 1'b0, 0);
      wait_drained();

      // width below the minimum acts as MIN_WIDTH; column 6 wraps at once
      write_width(0);
      send_block(1, 2, PAT_WHITE, 1'b0, 0);
      send_block(5, gbsg_pkg::MIN_WIDTH, PAT_VEDGE, 1'b1, 0);
      send_block(1, gbsg_pkg::MIN_WIDTH, PAT_CHECKER, 1'b0, 0);

      // long result hold with the source still pushing, then a mid-frame drain
      wait_drained();
      write_width(8);
      send_block(5, 8, PAT_RANDOM, 1'b1, 0);
      rsp_hold_request = 1'b1;
      send_block(6, 8, PAT_CHECKER, 1'b0, 0);
      wait_drained();
      send_block(2, 8, PAT_SPECKLE, 1'b0, 0);

      // random phases: mostly clean frames, some stray frame starts and torn rows
      random_target = items_sent + RANDOM_ITEMS;
      while (items_sent < random_target) begin
         wait_drained();
         case ($urandom_range(0, 9))
            0:       value = $urandom_range(0, gbsg_pkg::MIN_WIDTH - 1);
            7, 8:    value = $urandom_range(13, 40);
            9:       value = $urandom_range(41, 96);
            default: value = $urandom_range(gbsg_pkg::MIN_WIDTH, 12);
         endcase
         write_width(value);
         ew = (value < gbsg_pkg::MIN_WIDTH) ? gbsg_pkg::MIN_WIDTH : value;
         send_idle_pct = pick_idle_pct();
         recv_idle_pct = pick_idle_pct();
         pat = ($urandom_range(0, 1) != 0) ? PAT_RANDOM
                                           : pattern_type'($urandom_range(0, int'(PAT_SPECKLE)));
         rows = $urandom_range(5, 8);
         new_frame = ($urandom_range(0, 9) != 0);
         send_block(rows, ew, pat, new_frame, ($urandom_range(0, 1) != 0) ? 0 : 5);
         if ($urandom_range(0, 3) == 0)
            send_block(1, $urandom_range(1, ew), PAT_RANDOM, 1'b0, 0);
      end

      // widest row: open four narrow rows, then a register above MAX_WIDTH acts as
      // MAX_WIDTH, so the one wide row yields gradients and wraps at its last column
      wait_drained();
      write_width(gbsg_pkg::MIN_WIDTH);
      send_idle_pct = 10;
      recv_idle_pct = 10;
      send_block(4, gbsg_pkg::MIN_WIDTH, PAT_RANDOM, 1'b1, 0);
      wait_drained();
      write_width(CSR_MAX);
      send_block(1, MAX_WIDTH, PAT_RANDOM, 1'b0, 0);
      send_block(1, 8, PAT_VEDGE, 1'b0, 0);

      // keep going at a new width, no frame start
      wait_drained();
      write_width(6);
      send_idle_pct = 30;
      recv_idle_pct = 30;
      send_block(5, 6, PAT_SPECKLE, 1'b0, 0);

      wait_drained();
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
design/gbsg_pkg.sv
design/gbsg_req_if.sv
design/gbsg_rsp_if.sv
design/gbsg_raw_stage.sv
design/gbsg_blur_stage.sv
design/gaussian_blur_sobel_gradient_core.sv
dv/gaussian_blur_sobel_gradient_checker.sv
dv/gaussian_blur_sobel_gradient_core_tb.sv
